// ----- hdl/mip_chain_box_downsampler_unit_defines.svh -----
// ----------------------------------------------------------------------------
// mip chain box downsampler assertion macros
// shared concurrent assertion shorthands, clocked on clk, disabled in rst
// ----------------------------------------------------------------------------
`ifndef MIP_CHAIN_BOX_DOWNSAMPLER_UNIT_DEFINES_SVH
`define MIP_CHAIN_BOX_DOWNSAMPLER_UNIT_DEFINES_SVH

// same-cycle implication
`define MCBD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// mcbd_pkg
// types and constants shared by the mip chain box downsampler modules
// ----------------------------------------------------------------------------
`default_nettype none

package mcbd_pkg;

  // fixed field widths
  localparam int ChanW     = 8;
  localparam int SizeW     = 4;
  localparam int LevelW    = 4;
  localparam int CoordW    = 9;
  localparam int NumChan   = 4;
  localparam int PairW     = ChanW + 1;
  localparam int PairWordW = NumChan * PairW;

  // input pixel transaction
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } pix_t;

  // result transaction
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [ChanW-1:0]  avg_red;
    logic [ChanW-1:0]  avg_green;
    logic [ChanW-1:0]  avg_blue;
    logic [ChanW-1:0]  avg_alpha;
    logic              last;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic hold_wr;
    logic pair_wr;
    logic rd_en;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic c_odd;
    logic r_odd;
    logic lvl_done;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/mcbd_ram.sv -----
// ----------------------------------------------------------------------------
// mcbd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mcbd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mcbd_dpath.sv -----
// ----------------------------------------------------------------------------
// mcbd_dpath
// position counters, level work registers, pixel hold, pair-sum memory
// and result register of the mip chain box downsampler
// ----------------------------------------------------------------------------
`default_nettype none
`include "mip_chain_box_downsampler_unit_defines.svh"

module mcbd_dpath #(
  parameter int MAX_SIZE_LOG2 = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mcbd_pkg::pix_t                pix,
  input  wire logic                          res_stall,
  output logic                               res_valid,
  output mcbd_pkg::res_t                     res,
  input  wire logic                          cfg_wr,
  input  wire logic [mcbd_pkg::SizeW-1:0]    cfg_data,
  input  wire mcbd_pkg::cmd_t                cmd,
  output mcbd_pkg::sts_t                     sts
);

  localparam int CW    = MAX_SIZE_LOG2;
  localparam int LW    = $clog2(MAX_SIZE_LOG2 + 1);
  localparam int HW    = (MAX_SIZE_LOG2 > 1) ? $clog2(MAX_SIZE_LOG2) : 1;
  localparam int DEPTH = 1 << CW;
  localparam int NC    = mcbd_pkg::NumChan;
  localparam int CHW   = mcbd_pkg::ChanW;
  localparam int PW    = mcbd_pkg::PairW;

  // configuration and position counters
  logic [LW-1:0] lg;
  logic [CW-1:0] in_col;
  logic [CW-1:0] in_row;
  logic [CW-1:0] side_mask;

  // level work registers
  logic [NC-1:0][CHW-1:0] px;
  logic [CW-1:0]          c;
  logic [CW-1:0]          r;
  logic [LW-1:0]          lvl;
  logic [NC-1:0][PW-1:0]  pair_q;
  logic [NC-1:0][CHW-1:0] hold [MAX_SIZE_LOG2];

  // combinational helpers
  logic [HW-1:0]          lvl_idx;
  logic [LW-1:0]          lvl_next;
  logic [CW-1:0]          c_half;
  logic [CW-1:0]          r_half;
  logic [CW-1:0]          base;
  logic [CW-1:0]          idx;
  logic [NC-1:0][PW-1:0]  pair_sum;
  logic [NC-1:0][PW-1:0]  upper;
  logic [NC-1:0][CHW-1:0] avg;
  logic [PW:0]            quad [NC];

  // mask of valid column and row bits for the current image size
  always_comb begin
    for (int i = 0; i < CW; i++) begin
      side_mask[i] = (LW'(i) < lg);
    end
  end

  // level address and pair sums
  assign lvl_idx  = lvl[HW-1:0];
  assign lvl_next = lvl + LW'(1);
  assign c_half   = c >> 1;
  assign r_half   = r >> 1;
  assign base     = ~({CW{1'b1}} >> lvl);
  assign idx      = base + c_half;

  always_comb begin
    for (int ch = 0; ch < NC; ch++) begin
      pair_sum[ch] = {1'b0, hold[lvl_idx][ch]} + {1'b0, px[ch]};
      quad[ch]     = {1'b0, pair_q[ch]} + {1'b0, upper[ch]};
      avg[ch]      = quad[ch][PW:2];
    end
  end

  // pair sums of pending even rows, one region per level
  mcbd_ram #(
    .WIDTH (mcbd_pkg::PairWordW),
    .DEPTH (DEPTH)
  ) u_pair_ram (
    .clk     (clk),
    .wr_en   (cmd.pair_wr),
    .wr_addr (idx),
    .wr_data (pair_sum),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx),
    .rd_data (upper)
  );

  // size register and input position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      lg     <= '0;
      in_col <= '0;
      in_row <= '0;
    end else if (cfg_wr) begin
      if (cfg_data > mcbd_pkg::SizeW'(MAX_SIZE_LOG2)) begin
        lg <= LW'(MAX_SIZE_LOG2);
      end else begin
        lg <= LW'(cfg_data);
      end
      in_col <= '0;
      in_row <= '0;
    end else if (cmd.load) begin
      if (in_col == side_mask) begin
        in_col <= '0;
        if (in_row == side_mask) begin
          in_row <= '0;
        end else begin
          in_row <= in_row + CW'(1);
        end
      end else begin
        in_col <= in_col + CW'(1);
      end
    end
  end

  // level work registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px  <= {pix.red, pix.green, pix.blue, pix.alpha};
      c   <= in_col;
      r   <= in_row;
      lvl <= '0;
    end else if (cmd.emit) begin
      px  <= avg;
      c   <= c_half;
      r   <= r_half;
      lvl <= lvl_next;
    end
    if (cmd.rd_en) begin
      pair_q <= pair_sum;
    end
    if (cmd.hold_wr) begin
      hold[lvl_idx] <= px;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.level     <= mcbd_pkg::LevelW'(lvl_next);
      res.col       <= mcbd_pkg::CoordW'(c_half);
      res.row       <= mcbd_pkg::CoordW'(r_half);
      res.avg_red   <= avg[3];
      res.avg_green <= avg[2];
      res.avg_blue  <= avg[1];
      res.avg_alpha <= avg[0];
      res.last      <= sts.emit_last;
    end
  end

  // status to controller
  always_comb begin
    sts.c_odd     = c[0];
    sts.r_odd     = r[0];
    sts.lvl_done  = (lvl == lg);
    sts.out_free  = !res_valid || !res_stall;
    sts.emit_last = (lvl_next == lg) || !c_half[0] || !r_half[0];
  end

  // assertions
  `MCBD_ASSERT_IMPL(a_emit_slot_free, cmd.emit, !(res_valid && res_stall), "result overwritten")
  `MCBD_ASSERT_IMPL(a_emit_level_range, cmd.emit, lvl < lg, "level beyond image size")
  `MCBD_ASSERT_IMPL(a_ram_one_op, cmd.pair_wr, !cmd.rd_en && !cmd.hold_wr, "conflicting level ops")

endmodule

`default_nettype wire

// ----- hdl/mcbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcbd_ctrl
// state machine that walks one input pixel through the mip levels
// ----------------------------------------------------------------------------
`default_nettype none
`include "mip_chain_box_downsampler_unit_defines.svh"

module mcbd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pix_valid,
  output logic                pix_stall,
  output logic                cfg_ready,
  input  wire mcbd_pkg::sts_t sts,
  output mcbd_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_CALC
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (pix_valid) begin
          cmd.load   = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.lvl_done) begin
          state_next = S_IDLE;
        end else if (!sts.c_odd) begin
          cmd.hold_wr = 1'b1;
          state_next  = S_IDLE;
        end else if (!sts.r_odd) begin
          cmd.pair_wr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        // the next level may still park its pixel or pair sum, or average again
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_STEP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // handshake outputs
  assign pix_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // assertions
  `MCBD_ASSERT_IMPL(a_calc_after_read, state == S_CALC, $past(state) == S_STEP || $past(state) == S_CALC, "average without read")
  `MCBD_ASSERT_NEXT(a_last_ends_item, cmd.emit && sts.emit_last, !cmd.rd_en, "level walk continued after last")
  `MCBD_ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0(cmd), "conflicting commands")

endmodule

`default_nettype wire

// ----- hdl/mip_chain_box_downsampler_unit.sv -----
// ----------------------------------------------------------------------------
// mip_chain_box_downsampler_unit
// Streaming 2x2 box-filter mipmap generator. RGBA8 pixels of a square image,
// 2^size_log2 on a side, arrive in raster order; every completed 2x2 block of
// a level gives one pixel of the next level (truncated average), tagged with
// level, column and row, shallowest level first, with last set on the final
// result of each input pixel. A write of size_log2 restarts the image; values
// above MAX_SIZE_LOG2 saturate. Each level that an input pixel completes costs
// a read of the registered pair-sum memory followed by the averaging step,
// which waits while the result register is held by res_stall, and the levels
// of one pixel are walked one after another.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_chain_box_downsampler_unit #(
  parameter int MAX_SIZE_LOG2 = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       pix_valid,
  output logic                            pix_stall,
  input  wire mcbd_pkg::pix_t             pix,
  output logic                            res_valid,
  input  wire logic                       res_stall,
  output mcbd_pkg::res_t                  res,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [mcbd_pkg::SizeW-1:0] cfg_data
);

  mcbd_pkg::cmd_t cmd;
  mcbd_pkg::sts_t sts;
  logic           cfg_wr;

  // configuration transaction
  assign cfg_wr = cfg_valid && cfg_ready;

  // controller
  mcbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  mcbd_dpath #(
    .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res       (res),
    .cfg_wr    (cfg_wr),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ----- test/mip_chain_box_downsampler_unit_test.sv -----
// ----------------------------------------------------------------------------
// mip_chain_box_downsampler_unit_test
// Self-checking bench for the streaming 2x2 box-filter mip generator. Pixels
// are pushed in raster order under several image sizes. A scoreboard object
// carries its own copy of the position counters and level line buffers and
// predicts every level pixel, which is compared field by field with each
// accepted result. Both channels idle at random, and one phase holds the
// result side off long enough to back up the pixel input.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_chain_box_downsampler_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ChanW         = mcbd_pkg::ChanW;
  localparam int SizeW         = mcbd_pkg::SizeW;
  localparam int LevelW        = mcbd_pkg::LevelW;
  localparam int CoordW        = mcbd_pkg::CoordW;
  localparam int NumChan       = mcbd_pkg::NumChan;
  localparam int PairW         = mcbd_pkg::PairW;
  localparam int MaxLog2       = 10;
  localparam int MaxSide       = 1 << MaxLog2;
  localparam int SettleCycles  = 8;
  localparam int EndCycles     = 40;
  localparam int LongHold      = 300;
  localparam int WatchdogLimit = 3000;

  // prediction of level pixels and the queue of results still owed
  class mip_cascade_board;
    logic [SizeW-1:0] size_log2;
    int unsigned      col;
    int unsigned      row;
    logic [NumChan-1:0][PairW-1:0] row_pairs [MaxSide];
    logic [NumChan-1:0][ChanW-1:0] held_left [MaxLog2];
    mcbd_pkg::res_t   expected_mips [$];
    int               errors;

    function new();
      size_log2 = '0;
      col = 0;
      row = 0;
      errors = 0;
    endfunction

    function void set_size(logic [SizeW-1:0] size);
      size_log2 = size;
      col = 0;
      row = 0;
    endfunction

    function int pending();
      return expected_mips.size();
    endfunction

    // walk the level cascade for one accepted pixel
    function void push_pixel(mcbd_pkg::pix_t p);
      int unsigned lg;
      int unsigned side;
      int unsigned c;
      int unsigned r;
      int unsigned idx;
      int unsigned total;
      logic [NumChan-1:0][ChanW-1:0] px;
      logic [NumChan-1:0][PairW-1:0] pair;
      mcbd_pkg::res_t pend;
      bit have_pend;
      lg = (size_log2 > MaxLog2) ? MaxLog2 : size_log2;
      side = 1 << lg;
      c = col;
      r = row;
      px = p;
      have_pend = 1'b0;
      for (int lvl = 0; lvl < lg; lvl++) begin
        idx = (MaxSide - (MaxSide >> lvl) + (c >> 1)) & (MaxSide - 1);
        // even column: park the pixel until its right neighbor shows up
        if (c[0] == 1'b0) begin
          held_left[lvl] = px;
          break;
        end
        for (int ch = 0; ch < NumChan; ch++)
          pair[ch] = {1'b0, held_left[lvl][ch]} + {1'b0, px[ch]};
        // even row: keep the pair sum for the row below
        if (r[0] == 1'b0) begin
          row_pairs[idx] = pair;
          break;
        end
        for (int ch = 0; ch < NumChan; ch++) begin
          total = pair[ch] + row_pairs[idx][ch];
          px[ch] = total[ChanW+1:2];
        end
        c = c >> 1;
        r = r >> 1;
        if (have_pend)
          expected_mips = {expected_mips, pend};
        pend.level = LevelW'(lvl + 1);
        pend.col = c[CoordW-1:0];
        pend.row = r[CoordW-1:0];
        {pend.avg_red, pend.avg_green, pend.avg_blue, pend.avg_alpha} = px;
        pend.last = 1'b0;
        have_pend = 1'b1;
      end
      if (have_pend) begin
        pend.last = 1'b1;
        expected_mips = {expected_mips, pend};
      end
      // raster position, wrapping at image end
      col++;
      if (col >= side) begin
        col = 0;
        row++;
        if (row >= side)
          row = 0;
      end
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task compare_field(string name, int got_v, int want_v, mcbd_pkg::res_t want);
      if (got_v != want_v)
        report($sformatf("%s got %0d want %0d (level %0d col %0d row %0d)",
                         name, got_v, want_v, want.level, want.col, want.row));
    endtask

    task check_result(mcbd_pkg::res_t got);
      mcbd_pkg::res_t want;
      if (expected_mips.size() == 0) begin
        report($sformatf("unexpected result level %0d col %0d row %0d",
                         got.level, got.col, got.row));
        return;
      end
      want = expected_mips.pop_front();
      compare_field("level", got.level, want.level, want);
      compare_field("col", got.col, want.col, want);
      compare_field("row", got.row, want.row, want);
      compare_field("avg_red", got.avg_red, want.avg_red, want);
      compare_field("avg_green", got.avg_green, want.avg_green, want);
      compare_field("avg_blue", got.avg_blue, want.avg_blue, want);
      compare_field("avg_alpha", got.avg_alpha, want.avg_alpha, want);
      compare_field("last", got.last, want.last, want);
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             pix_valid = 1'b0;
  logic             pix_stall;
  mcbd_pkg::pix_t   pix = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  mcbd_pkg::res_t   res;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [SizeW-1:0] cfg_data = '0;

  mip_cascade_board sb;
  bit               idle_on = 1'b0;
  int               hold_len = 0;
  int               quiet_cycles = 0;

  always #5 clk = ~clk;

  mip_chain_box_downsampler_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // channel values lean on the extremes
  function automatic logic [ChanW-1:0] rand_chan();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return ChanW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic mcbd_pkg::pix_t rand_pixel();
    mcbd_pkg::pix_t p;
    p.red = rand_chan();
    p.green = rand_chan();
    p.blue = rand_chan();
    p.alpha = rand_chan();
    return p;
  endfunction

  // one pixel transaction, with an optional gap ahead of it
  task automatic send_pixel(input mcbd_pkg::pix_t p);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix <= p;
    do @(posedge clk); while (pix_stall);
    sb.push_pixel(p);
  endtask

  task automatic write_size(input logic [SizeW-1:0] size);
    cfg_valid <= 1'b1;
    cfg_data <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_size(size);
  endtask

  // wait for all owed results plus the tail of a pixel that gives none
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic run_phase(input logic [SizeW-1:0] size, input int count,
                           input bit idle, input int hold);
    settle();
    write_size(size);
    idle_on = idle;
    hold_len = hold;
    repeat (count) send_pixel(rand_pixel());
    pix_valid <= 1'b0;
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int gap;
    wait (!rst);
    forever begin
      if (hold_len > 0) begin
        gap = hold_len;
        hold_len = 0;
      end else begin
        gap = idle_on ? $urandom_range(0, 7) : 0;
      end
      if (gap > 0) begin
        res_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
      sb.check_result(res);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("ERROR: no transaction for %0d cycles", quiet_cycles);
      $display("mip_chain_box_downsampler_unit_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset size: 1x1 image, nothing comes out
    send_pixel(mcbd_pkg::pix_t'({4{8'h00}}));
    send_pixel(mcbd_pkg::pix_t'({4{8'hff}}));
    pix_valid <= 1'b0;

    // one row, then a rewrite restarts the image
    settle();
    write_size(4'd1);
    send_pixel(rand_pixel());
    send_pixel(rand_pixel());
    pix_valid <= 1'b0;
    settle();
    write_size(4'd1);

    // 2x2 images back to back: all ones, all zeros, truncating mix
    repeat (4) send_pixel(mcbd_pkg::pix_t'({4{8'hff}}));
    repeat (4) send_pixel(mcbd_pkg::pix_t'({4{8'h00}}));
    send_pixel(mcbd_pkg::pix_t'({8'd255, 8'd1, 8'd0, 8'd128}));
    send_pixel(mcbd_pkg::pix_t'({8'd255, 8'd1, 8'd1, 8'd64}));
    send_pixel(mcbd_pkg::pix_t'({8'd255, 8'd1, 8'd2, 8'd32}));
    send_pixel(mcbd_pkg::pix_t'({8'd254, 8'd0, 8'd3, 8'd16}));
    pix_valid <= 1'b0;

    // random content under a range of sizes
    run_phase(4'd2, 32, 1'b1, 0);
    run_phase(4'd3, 64, 1'b0, LongHold);
    run_phase(4'd3, 8, 1'b1, 0);
    run_phase(4'd4, 12, 1'b1, 0);
    run_phase(4'd1, 8, 1'b1, 0);
    run_phase(4'd0, 4, 1'b1, 0);
    // oversized size saturates to the maximum
    run_phase(4'd15, 8, 1'b0, 0);
    run_phase(4'd10, 8, 1'b1, 0);
    repeat (2)
      run_phase(SizeW'($urandom_range(0, 5)), $urandom_range(4, 10),
                1'($urandom_range(0, 1)), 0);
    run_phase(4'd2, 8, 1'b1, 0);

    // drain and finish
    while (sb.pending() != 0) @(posedge clk);
    repeat (EndCycles) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("mip_chain_box_downsampler_unit_test OK");
    else
      $display("mip_chain_box_downsampler_unit_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
